/* sv/kmeans_nearest_centroid_cost_unit_defines.svh */
// ----------------------------------------------------------------------------
// kmeans_nearest_centroid_cost_unit_defines
// Assertion macros for the nearest centroid cost unit.
// ----------------------------------------------------------------------------
`ifndef KMEANS_NEAREST_CENTROID_COST_UNIT_DEFINES_SVH
`define KMEANS_NEAREST_CENTROID_COST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define KNCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kncc: same-cycle check failed");
`define KNCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kncc: next-cycle check failed");
`else
`define KNCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KNCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/kncc_pkg.sv */
// ----------------------------------------------------------------------------
// kncc_pkg
// Shared types and fixed field widths of the nearest centroid cost unit.
// ----------------------------------------------------------------------------
package kncc_pkg;

    localparam int IDX_W      = 4;
    localparam int FIELD_W    = 16;
    localparam int CNT_W      = 4;
    localparam int DIST_OUT_W = 33;
    localparam int COST_W     = 48;
    localparam int S_DATA_W   = 40;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 88;
    localparam int M_USER_W   = 1;

    localparam logic [CNT_W-1:0]  CNT_RESET = 4'd3;
    localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_ACC
    } t_state;

    // one centroid read in flight
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_tag;

endpackage

/* sv/kncc_store.sv */
// ----------------------------------------------------------------------------
// kncc_store
// Centroid store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kncc_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/kncc_dist.sv */
// ----------------------------------------------------------------------------
// kncc_dist
// Pipelined squared distance unit with running minimum search.
// ----------------------------------------------------------------------------
module kncc_dist #(
    parameter int COORD_BITS = 16,
    parameter int ADDR_W     = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kncc_pkg::t_tag            i_tag,
    input  logic [2*COORD_BITS-1:0]   i_rd_data,
    input  logic [COORD_BITS-1:0]     i_px,
    input  logic [COORD_BITS-1:0]     i_py,
    output logic                      o_done,
    output logic [ADDR_W-1:0]         o_best_idx,
    output logic [2*COORD_BITS:0]     o_best_dist
);

    import kncc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 1;

    t_tag            r1_tag, r2_tag, r3_tag;
    logic [CB-1:0]   w_cx, w_cy, w_dx, w_dy;
    logic [CB-1:0]   r2_dx, r2_dy;
    logic [2*CB-1:0] r3_sqx, r3_sqy;
    logic [DW-1:0]   w_d;
    logic [ADDR_W-1:0] w_idx, r_cur_idx, r_best_idx;
    logic [DW-1:0]   r_best_d;
    logic            r_done;

    assign w_cx = i_rd_data[CB-1:0];
    assign w_cy = i_rd_data[2*CB-1:CB];
    assign w_dx = (i_px >= w_cx) ? (i_px - w_cx) : (w_cx - i_px);
    assign w_dy = (i_py >= w_cy) ? (i_py - w_cy) : (w_cy - i_py);

    assign w_d   = DW'(r3_sqx) + DW'(r3_sqy);
    assign w_idx = r3_tag.first ? '0 : r_cur_idx + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r_done <= 1'b0;
        end else begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r_done <= r3_tag.vld && r3_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_dx  <= w_dx;
        r2_dy  <= w_dy;
        r3_sqx <= r2_dx * r2_dx;
        r3_sqy <= r2_dy * r2_dy;
        if (r3_tag.vld) begin
            r_cur_idx <= w_idx;
            // strict compare: lower index keeps ties
            if (r3_tag.first || (w_d < r_best_d)) begin
                r_best_d   <= w_d;
                r_best_idx <= w_idx;
            end
        end
    end

    assign o_done      = r_done;
    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best_d;

endmodule

/* sv/kmeans_nearest_centroid_cost_unit.sv */
// ----------------------------------------------------------------------------
// kmeans_nearest_centroid_cost_unit
// k-means assignment step: nearest centroid search with running cost sum.
// ----------------------------------------------------------------------------
// Load item: written into the centroid store, no result.
// Point item: the search runs over N store entries, N = clamped centroid count
//   (2..15); the single distance pipeline reads one store entry per cycle.
// Not ready from a point transfer until its result is in the output register,
//   so a new point is taken only once the last one's result is registered.
// Reset clears control, cost sum, saturation flag and sets count to 3; the
//   centroid store is not cleared.
module kmeans_nearest_centroid_cost_unit #(
    parameter int MAX_CENTROIDS = 16,
    parameter int COORD_BITS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [kncc_pkg::CNT_W-1:0]      i_cfg_wr_data,   // num_centroids
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // centroid_index[3:0], coord_x[19:4], coord_y[35:20], zero pad
    input  logic [kncc_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // mode[0], first_point[1]
    input  logic [kncc_pkg::S_USER_W-1:0]   i_s_axis_tuser,
    input  logic                            i_s_axis_tlast,  // last_point
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // nearest_index[3:0], min_dist_sq[36:4], total_cost[84:37], zero pad
    output logic [kncc_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // cost_saturated[0]
    output logic [kncc_pkg::M_USER_W-1:0]   o_m_axis_tuser,
    output logic                            o_m_axis_tlast   // cost_final
);

    import kncc_pkg::*;

`include "kmeans_nearest_centroid_cost_unit_defines.svh"

    localparam int AW  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int CB  = COORD_BITS;
    localparam int DW  = 2 * COORD_BITS + 1;
    localparam int SW  = ((DW > COST_W) ? DW : COST_W) + 1;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_num;
    logic [AW-1:0]     r_addr, r_last_addr;
    logic [CB-1:0]     r_px, r_py;
    logic              r_first, r_last;
    logic [COST_W-1:0] r_cost;
    logic              r_sat;
    logic              r_out_vld;
    logic [AW-1:0]     r_out_idx;
    logic [DW-1:0]     r_out_dist;
    logic [COST_W-1:0] r_out_cost;
    logic              r_out_sat, r_out_last;

    logic              w_accept, w_mode, w_commit, w_we, w_done;
    logic [IDX_W-1:0]  w_cidx;
    logic [CB-1:0]     w_in_x, w_in_y;
    logic [7:0]        w_cnt;
    logic [AW-1:0]     w_best_idx;
    logic [DW-1:0]     w_best_dist;
    logic [2*CB-1:0]   w_rd_data;
    t_tag              w_tag;
    logic [COST_W-1:0] w_base_cost;
    logic              w_base_sat;
    logic [SW-1:0]     w_sum;
    logic [COST_W-1:0] w_new_cost;
    logic              w_new_sat;

    assign w_cidx = i_s_axis_tdata[IDX_W-1:0];
    assign w_in_x = CB'(i_s_axis_tdata[IDX_W+FIELD_W-1:IDX_W]);
    assign w_in_y = CB'(i_s_axis_tdata[IDX_W+2*FIELD_W-1:IDX_W+FIELD_W]);
    assign w_mode = i_s_axis_tuser[0];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_we = w_accept && (w_mode == MODE_LOAD) && (32'(w_cidx) < MAX_CENTROIDS);

    always_comb begin
        w_cnt = 8'(r_num);
        if (w_cnt < 8'd2) begin
            w_cnt = 8'd2;
        end
        if (w_cnt > 8'(MAX_CENTROIDS)) begin
            w_cnt = 8'(MAX_CENTROIDS);
        end
    end

    kncc_store #(
        .DEPTH  (MAX_CENTROIDS),
        .ADDR_W (AW),
        .DATA_W (2*CB)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_cidx)),
        .i_wdata ({w_in_y, w_in_x}),
        .i_re    (w_tag.vld),
        .i_raddr (r_addr),
        .o_rdata (w_rd_data)
    );

    kncc_dist #(
        .COORD_BITS (CB),
        .ADDR_W     (AW)
    ) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (w_tag),
        .i_rd_data   (w_rd_data),
        .i_px        (r_px),
        .i_py        (r_py),
        .o_done      (w_done),
        .o_best_idx  (w_best_idx),
        .o_best_dist (w_best_dist)
    );

    // cost accumulate with saturation
    always_comb begin
        w_base_cost = r_first ? '0 : r_cost;
        w_base_sat  = r_first ? 1'b0 : r_sat;
        w_sum       = SW'(w_base_cost) + SW'(w_best_dist);
        if (w_sum > SW'(COST_MAX)) begin
            w_new_cost = COST_MAX;
            w_new_sat  = 1'b1;
        end else begin
            w_new_cost = w_sum[COST_W-1:0];
            w_new_sat  = w_base_sat;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_tag     = '0;
        w_commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_mode == MODE_POINT)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_tag.vld   = 1'b1;
                w_tag.first = (r_addr == '0);
                w_tag.last  = (r_addr == r_last_addr);
                if (r_addr == r_last_addr) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_num     <= CNT_RESET;
            r_addr    <= '0;
            r_cost    <= '0;
            r_sat     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_num <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_addr <= '0;
            end else if (w_tag.vld) begin
                r_addr <= r_addr + AW'(1);
            end
            if (w_commit) begin
                r_cost    <= w_new_cost;
                r_sat     <= w_new_sat;
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px        <= w_in_x;
            r_py        <= w_in_y;
            r_first     <= i_s_axis_tuser[1];
            r_last      <= i_s_axis_tlast;
            r_last_addr <= AW'(w_cnt - 8'd1);
        end
        if (w_commit) begin
            r_out_idx  <= w_best_idx;
            r_out_dist <= w_best_dist;
            r_out_cost <= w_new_cost;
            r_out_sat  <= w_new_sat;
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = {3'b000, r_out_cost, DIST_OUT_W'(r_out_dist), IDX_W'(r_out_idx)};
    assign o_m_axis_tuser[0] = r_out_sat;
    assign o_m_axis_tlast    = r_out_last;

    `KNCC_ASSERT_IMPLY(a_sat_at_ceiling, i_clk, i_rst_n, r_out_vld && r_out_sat, r_out_cost == COST_MAX)
    `KNCC_ASSERT_IMPLY(a_done_in_wait, i_clk, i_rst_n, w_done, r_state == ST_WAIT)
    `KNCC_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, w_commit, r_out_vld && (r_state == ST_IDLE))
    `KNCC_ASSERT_NEXT(a_point_scans, i_clk, i_rst_n, w_accept && (w_mode == MODE_POINT), r_state == ST_SCAN)

endmodule

/* tb/kncc_result_checker.sv */
// ----------------------------------------------------------------------------
// kncc_result_checker
// Watches both stream channels and the count register of the nearest centroid
// cost unit. Keeps its own centroid store and cost sum, predicts each point's
// assignment and compares it with the result stream in order.
// ----------------------------------------------------------------------------
module kncc_result_checker
    import kncc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CNT_W-1:0]    i_cfg_wr_data,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic [S_USER_W-1:0] i_s_tuser,
    input  logic                i_s_tlast,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,
    input  logic [M_USER_W-1:0] i_m_tuser,
    input  logic                i_m_tlast,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0]      nearest;
        logic [DIST_OUT_W-1:0] dist_sq;
        logic [COST_W-1:0]     cost;
        logic                  sat;
        logic                  fin;
    } t_assign;

    logic [FIELD_W-1:0] centroid_x [16];
    logic [FIELD_W-1:0] centroid_y [16];
    logic [COST_W-1:0]  cost_acc;
    logic               cost_sat;
    logic [CNT_W-1:0]   search_count;
    t_assign            expected_assign_q [$];
    int                 fail_count = 0;

    function automatic t_assign nearest_centroid_cost(input logic [FIELD_W-1:0] px,
                                                      input logic [FIELD_W-1:0] py,
                                                      input logic first,
                                                      input logic last);
        t_assign         res;
        int              n;
        int              best_i;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned d;
        longint unsigned best;
        n = (search_count < 2) ? 2 : int'(search_count);
        best = 0;
        best_i = 0;
        for (int i = 0; i < n; i++) begin
            dx = (px >= centroid_x[i]) ? px - centroid_x[i] : centroid_x[i] - px;
            dy = (py >= centroid_y[i]) ? py - centroid_y[i] : centroid_y[i] - py;
            d = dx * dx + dy * dy;
            if (i == 0 || d < best) begin
                best = d;
                best_i = i;
            end
        end
        if (first) begin
            cost_acc = '0;
            cost_sat = 1'b0;
        end
        if (best > COST_MAX - cost_acc) begin
            cost_acc = COST_MAX;
            cost_sat = 1'b1;
        end else begin
            cost_acc = cost_acc + best[COST_W-1:0];
        end
        res.nearest = best_i[IDX_W-1:0];
        res.dist_sq = best[DIST_OUT_W-1:0];
        res.cost    = cost_acc;
        res.sat     = cost_sat;
        res.fin     = last;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_assign got;
        t_assign want;
        t_assign pred;
        logic [IDX_W-1:0] idx;
        if (!i_rst_n) begin
            cost_acc = '0;
            cost_sat = 1'b0;
            search_count = CNT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                search_count = i_cfg_wr_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.nearest = i_m_tdata[IDX_W-1:0];
                got.dist_sq = i_m_tdata[IDX_W +: DIST_OUT_W];
                got.cost    = i_m_tdata[IDX_W+DIST_OUT_W +: COST_W];
                got.sat     = i_m_tuser[0];
                got.fin     = i_m_tlast;
                if (expected_assign_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t unexpected result idx=%0d dist=%0d cost=%0d sat=%0b last=%0b",
                                 $time, got.nearest, got.dist_sq, got.cost, got.sat, got.fin);
                    end
                end else begin
                    want = expected_assign_q.pop_front();
                    if (got.nearest !== want.nearest || got.dist_sq !== want.dist_sq ||
                        got.cost !== want.cost || got.sat !== want.sat ||
                        got.fin !== want.fin) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t mismatch: want idx=%0d dist=%0d cost=%0d sat=%0b last=%0b",
                                     $time, want.nearest, want.dist_sq, want.cost, want.sat,
                                     want.fin);
                            $display("%0t          got  idx=%0d dist=%0d cost=%0d sat=%0b last=%0b",
                                     $time, got.nearest, got.dist_sq, got.cost, got.sat,
                                     got.fin);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                idx = i_s_tdata[IDX_W-1:0];
                if (i_s_tuser[0] == MODE_LOAD) begin
                    centroid_x[idx] = i_s_tdata[IDX_W +: FIELD_W];
                    centroid_y[idx] = i_s_tdata[IDX_W+FIELD_W +: FIELD_W];
                end else begin
                    pred = nearest_centroid_cost(i_s_tdata[IDX_W +: FIELD_W],
                                                 i_s_tdata[IDX_W+FIELD_W +: FIELD_W],
                                                 i_s_tuser[1], i_s_tlast);
                    expected_assign_q = {expected_assign_q, pred};
                end
            end
        end
        o_pending    <= expected_assign_q.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the nearest centroid cost unit: directed corner points, a long
// set of farthest points that builds a large cost sum, then random centroid
// loads and point sets across several centroid counts, with random stalls on
// both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kncc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 7;
    localparam int WDOG_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int SAT_POINTS   = 96;
    localparam int RAND_ITEMS   = 1680;
    localparam int NUM_PHASES   = 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    int                  fail_count;
    int                  pending;
    int                  hold_req = 0;
    int                  hold_done = 0;
    bit                  rx_quiet = 1'b0;
    logic [FIELD_W-1:0]  shadow_x [16] = '{default: '0};
    logic [FIELD_W-1:0]  shadow_y [16] = '{default: '0};

    kmeans_nearest_centroid_cost_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    kncc_result_checker u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_gap(input bit quiet);
        if (quiet || $urandom_range(0, 99) < 60) return 0;
        return stall_len();
    endfunction

    // corners, points near a loaded centroid, or anywhere
    function automatic logic [2*FIELD_W-1:0] rand_point();
        int r;
        int k;
        int px;
        int py;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            px = $urandom_range(0, 1) * 65535;
            py = $urandom_range(0, 1) * 65535;
        end else if (r < 50) begin
            k = $urandom_range(0, 14);
            px = int'(shadow_x[k]) + int'($urandom_range(0, 64)) - 32;
            py = int'(shadow_y[k]) + int'($urandom_range(0, 64)) - 32;
        end else begin
            px = $urandom_range(0, 65535);
            py = $urandom_range(0, 65535);
        end
        px = (px < 0) ? 0 : ((px > 65535) ? 65535 : px);
        py = (py < 0) ? 0 : ((py > 65535) ? 65535 : py);
        return {py[FIELD_W-1:0], px[FIELD_W-1:0]};
    endfunction

    function automatic logic [CNT_W-1:0] count_for_phase(input int p);
        case (p)
            0: return 4'd15;
            1: return 4'd0;
            2: return 4'd9;
            3: return 4'd1;
            4: return 4'd2;
            5: return 4'd15;
            default: return CNT_W'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                             input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                             input logic first, input logic last, input bit quiet);
        int gap;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-IDX_W-2*FIELD_W){1'b0}}, y, x, idx};
        s_tuser  <= {first, mode};
        s_tlast  <= last;
        if (mode == MODE_LOAD) begin
            shadow_x[idx] = x;
            shadow_y[idx] = y;
        end
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // wait for every outstanding result, then let a trailing load retire
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side: random stalls plus requested long hold-offs
    always begin
        @(posedge clk);
        if (hold_req != hold_done) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            m_tready  <= 1'b1;
            hold_done <= hold_done + 1;
        end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            repeat (stall_len()) @(posedge clk);
            m_tready <= 1'b1;
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int                  phase;
        int                  done_items;
        int                  n;
        int                  r;
        bit                  quiet;
        bit                  noisy;
        logic                f;
        logic                l;
        logic [2*FIELD_W-1:0] pt;

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ties, exact hits, far corners, single point set
        send_item(MODE_LOAD, 4'd0, 16'h0100, 16'h0100, 1'b0, 1'b0, 1'b0);
        send_item(MODE_LOAD, 4'd1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
        send_item(MODE_LOAD, 4'd2, 16'h0100, 16'h0100, 1'b0, 1'b0, 1'b0);
        send_item(MODE_LOAD, 4'd15, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_item(MODE_POINT, 4'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_item(MODE_POINT, 4'd15, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_item(MODE_POINT, 4'd0, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_item(MODE_POINT, 4'd0, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        send_item(MODE_POINT, 4'd0, 16'h0100, 16'h0100, 1'b1, 1'b1, 1'b0);
        write_count(4'd0);
        send_item(MODE_LOAD, 4'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_item(MODE_LOAD, 4'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_item(MODE_POINT, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_item(MODE_POINT, 4'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        write_count(4'd1);
        send_item(MODE_LOAD, 4'd1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_item(MODE_POINT, 4'd0, 16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0);

        // one long set of farthest points builds a large cost sum
        write_count(4'd2);
        send_item(MODE_LOAD, 4'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        rx_quiet <= 1'b1;
        for (int i = 0; i < SAT_POINTS; i++) begin
            send_item(MODE_POINT, 4'd0, 16'hFFFF, 16'hFFFF, i == 0, i == SAT_POINTS - 1, 1'b1);
        end
        send_item(MODE_POINT, 4'd0, 16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1);
        rx_quiet <= 1'b0;

        for (int i = 0; i < 16; i++) begin
            send_item(MODE_LOAD, i[IDX_W-1:0], 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0);
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_count(count_for_phase(phase));
            if (phase == 2) hold_req <= hold_req + 1;
            done_items = 0;
            while (done_items < RAND_ITEMS / NUM_PHASES) begin
                quiet = ($urandom_range(0, 4) == 0);
                rx_quiet <= quiet;
                if ($urandom_range(0, 99) < 15) begin
                    n = $urandom_range(1, 4);
                    for (int j = 0; j < n; j++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            r = $urandom_range(0, 15);
                            pt = {shadow_y[r], shadow_x[r]};
                        end else begin
                            pt = rand_point();
                        end
                        send_item(MODE_LOAD, IDX_W'($urandom_range(0, 15)),
                                  pt[FIELD_W-1:0], pt[2*FIELD_W-1:FIELD_W],
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), quiet);
                    end
                end else begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                    : $urandom_range(1, 12);
                    noisy = ($urandom_range(0, 9) == 0);
                    for (int j = 0; j < n; j++) begin
                        f = noisy ? 1'($urandom_range(0, 1)) : (j == 0);
                        l = noisy ? 1'($urandom_range(0, 1)) : (j == n - 1);
                        pt = rand_point();
                        send_item(MODE_POINT, IDX_W'($urandom_range(0, 15)),
                                  pt[FIELD_W-1:0], pt[2*FIELD_W-1:FIELD_W], f, l, quiet);
                    end
                end
                done_items += n;
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/kncc_pkg.sv
sv/kncc_store.sv
sv/kncc_dist.sv
sv/kmeans_nearest_centroid_cost_unit.sv
tb/kncc_result_checker.sv
tb/tb.sv
